[sv/scbpm_pkg.sv]
// Shared types and constants for the size-class buffer pool manager.
package scbpm_pkg;

  // Geometry of the pool set and the free-list memory
  localparam int POOLS      = 4;
  localparam int POOL_W     = 2;
  localparam int FREE_DEPTH = 64;
  localparam int HEAD_W     = 6;
  localparam int FILL_W     = 7;
  localparam int MEM_DEPTH  = POOLS * FREE_DEPTH;
  localparam int ADDR_W     = POOL_W + HEAD_W;

  // Heap layout
  localparam int HEAP_LIMIT        = 131072;
  localparam int LINK_BYTES        = 4;
  localparam int POOL_RECORD_BYTES = 16;
  localparam int HDR_BYTES         = 4;
  localparam int HDR_W             = 10;

  // Spill window for allocation lengths
  localparam int SPILL_LOW  = 384;
  localparam int SPILL_HIGH = 448;

  // Field widths
  localparam int LEN_W   = 16;
  localparam int OFF_W   = 17;
  localparam int HEAP_W  = 18;
  localparam int START_W = 18;
  localparam int CNT_W   = 7;
  localparam int NUM_W   = 3;
  localparam int STEP_W  = 17;
  localparam int PROD_W  = STEP_W + CNT_W;
  localparam int ACC_W   = 27;
  localparam int SPILL_W = 32;
  localparam int STAT_W  = 3;
  localparam int FUNC_W  = 2;
  localparam int ALU_W   = 28;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  typedef logic [ALU_W-1:0] alu_op_t;
  typedef logic [ALU_W:0]   alu_res_t;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POOLS_USED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BYTES  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL0_SETUP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL3_SETUP = 3'd5;

  // Register reset values
  localparam logic [NUM_W-1:0]  POOLS_USED_RST = 3'd1;
  localparam logic [HEAP_W-1:0] HEAP_BYTES_RST = 18'd131072;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STATUS_DONE       = 3'd0;
  localparam logic [STAT_W-1:0] STATUS_NO_FIT     = 3'd1;
  localparam logic [STAT_W-1:0] STATUS_BAD_REQ    = 3'd2;
  localparam logic [STAT_W-1:0] STATUS_HEAP_SMALL = 3'd3;
  localparam logic [STAT_W-1:0] STATUS_POOL_FULL  = 3'd4;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_I_START,
    ST_I_CHK,
    ST_I_ACC,
    ST_I_CMP,
    ST_L_POOL,
    ST_L_BUF,
    ST_A_SCAN,
    ST_A_TAKE,
    ST_F_CHK,
    ST_F_LO,
    ST_F_SCAN,
    ST_F_PUSH,
    ST_RESP
  } state_e;

endpackage

[sv/size_class_buffer_pool_manager_core.sv]
// Size-class buffer pool manager: sequencer, shared ALU, free-list memory.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid_i/in_ready_o, func_i, length_i,       | input
//          | buffer_offset_i                                |
//  out     | out_valid_o/out_ready_i, status_o,             | output
//          | data_offset_o, pool_index_o, buffers_left_o,   |
//          | spill_count_o                                  |
//  cfg     | cfg_we_i, cfg_index_i, cfg_wdata_i             | input
//
// One transaction at a time; in_ready_o is high only while the sequencer idles.
// Allocate scans the active pools in order through the shared compare and takes
// from the first that fits and is not empty. Free checks the offset, then compares
// it against the pool boundaries in turn. Init sums the pool sizes, checks the total
// against the heap, then lays out each pool and each of its buffers, writing one
// free-list entry per buffer through the memory write port. The result sits in an output register
// and the next transaction is taken once it has been loaded there.
// Reset clears pool state and loads the register defaults; free lists are
// not cleared, since entries are read only after being written.
module size_class_buffer_pool_manager_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [scbpm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [scbpm_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  // request
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [scbpm_pkg::FUNC_W-1:0]      func_i,
  input  logic [scbpm_pkg::LEN_W-1:0]       length_i,
  input  logic [scbpm_pkg::OFF_W-1:0]       buffer_offset_i,
  // response
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [scbpm_pkg::STAT_W-1:0]      status_o,
  output logic [scbpm_pkg::OFF_W-1:0]       data_offset_o,
  output logic [scbpm_pkg::POOL_W-1:0]      pool_index_o,
  output logic [scbpm_pkg::FILL_W-1:0]      buffers_left_o,
  output logic [scbpm_pkg::SPILL_W-1:0]     spill_count_o
);

  // Configuration registers
  logic [scbpm_pkg::NUM_W-1:0]      pools_used_q;
  logic [scbpm_pkg::HEAP_W-1:0]     heap_q;
  logic [scbpm_pkg::CFG_DATA_W-1:0] setup_q [scbpm_pkg::POOLS];

  // Sequencer and pool state
  scbpm_pkg::state_e                state_q, state_d;
  logic [scbpm_pkg::POOL_W-1:0]     k_q;
  logic [scbpm_pkg::CNT_W-1:0]      j_q;
  logic [scbpm_pkg::FILL_W-1:0]     fill_q  [scbpm_pkg::POOLS];
  logic [scbpm_pkg::HEAD_W-1:0]     head_q  [scbpm_pkg::POOLS];
  logic [scbpm_pkg::START_W-1:0]    start_q [scbpm_pkg::POOLS];
  logic [scbpm_pkg::LEN_W-1:0]      limit_q [scbpm_pkg::POOLS];
  logic [scbpm_pkg::NUM_W-1:0]      active_q;
  logic [scbpm_pkg::SPILL_W-1:0]    spill_q;
  logic                             out_valid_q;

  // Working registers
  logic [scbpm_pkg::FUNC_W-1:0]     func_q;
  logic [scbpm_pkg::LEN_W-1:0]      length_q;
  logic [scbpm_pkg::OFF_W-1:0]      boff_q;
  logic [scbpm_pkg::OFF_W-1:0]      link_q;
  logic [scbpm_pkg::ACC_W-1:0]      acc_q;
  logic [scbpm_pkg::PROD_W-1:0]     prod_q;
  logic [scbpm_pkg::START_W-1:0]    pos_q;
  logic [scbpm_pkg::STAT_W-1:0]     res_status_q;
  logic [scbpm_pkg::OFF_W-1:0]      res_off_q;
  logic [scbpm_pkg::POOL_W-1:0]     res_pool_q;
  logic [scbpm_pkg::FILL_W-1:0]     res_left_q;
  logic [scbpm_pkg::STAT_W-1:0]     out_status_q;
  logic [scbpm_pkg::OFF_W-1:0]      out_off_q;
  logic [scbpm_pkg::POOL_W-1:0]     out_pool_q;
  logic [scbpm_pkg::FILL_W-1:0]     out_left_q;
  logic [scbpm_pkg::SPILL_W-1:0]    out_spill_q;

  // Free-list memory
  logic [scbpm_pkg::OFF_W-1:0]      mem [scbpm_pkg::MEM_DEPTH];
  logic [scbpm_pkg::OFF_W-1:0]      mem_rdata_q;
  logic                             mem_we, mem_re;
  logic [scbpm_pkg::ADDR_W-1:0]     mem_waddr, mem_raddr;
  logic [scbpm_pkg::OFF_W-1:0]      mem_wdata;

  // Shared ALU
  scbpm_pkg::alu_op_t               alu_a, alu_b;
  logic                             alu_sub;
  scbpm_pkg::alu_res_t              alu_res;
  logic                             alu_ge;

  // Result staging
  logic                             res_ld;
  logic [scbpm_pkg::STAT_W-1:0]     res_status;
  logic [scbpm_pkg::OFF_W-1:0]      res_off;
  logic [scbpm_pkg::POOL_W-1:0]     res_pool;
  logic [scbpm_pkg::FILL_W-1:0]     res_left;
  logic                             lay_done;

  // Derived conditions
  logic                             accept;
  logic                             out_free;
  logic [scbpm_pkg::LEN_W-1:0]      cur_sz;
  logic [scbpm_pkg::CNT_W-1:0]      cur_cnt;
  logic [scbpm_pkg::STEP_W-1:0]     step;
  logic [scbpm_pkg::HDR_W-1:0]      hdr;
  logic [scbpm_pkg::HEAP_W-1:0]     heap_eff;
  logic [scbpm_pkg::POOL_W-1:0]     k_inc;
  logic [scbpm_pkg::NUM_W-1:0]      k_ext1;
  logic                             n_bad, k_in_n, cnt_bad, k_last, k_next_is_n, j_last;
  logic                             alloc_act, alloc_hit, spill_hit;
  logic                             free_bad_early, free_last, pool_full;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  assign cur_sz  = setup_q[k_q][15:0];
  assign cur_cnt = setup_q[k_q][22:16];
  assign step    = scbpm_pkg::STEP_W'(scbpm_pkg::LINK_BYTES) + {1'b0, cur_sz};

  // Header size: fixed word plus one record per pool, rounded up to 4 bytes
  assign hdr = (scbpm_pkg::HDR_W'(scbpm_pkg::HDR_BYTES + 3)
               + scbpm_pkg::HDR_W'(scbpm_pkg::POOL_RECORD_BYTES)
                 * {{(scbpm_pkg::HDR_W-scbpm_pkg::NUM_W){1'b0}}, pools_used_q})
               & ~scbpm_pkg::HDR_W'(3);

  assign heap_eff = (heap_q > scbpm_pkg::HEAP_W'(scbpm_pkg::HEAP_LIMIT))
                  ? scbpm_pkg::HEAP_W'(scbpm_pkg::HEAP_LIMIT) : heap_q;

  assign k_inc  = k_q + scbpm_pkg::POOL_W'(1);
  assign k_ext1 = {1'b0, k_q} + scbpm_pkg::NUM_W'(1);

  assign n_bad       = (pools_used_q == '0)
                    || (pools_used_q > scbpm_pkg::NUM_W'(scbpm_pkg::POOLS));
  assign k_in_n      = {1'b0, k_q} < pools_used_q;
  assign cnt_bad     = cur_cnt > scbpm_pkg::CNT_W'(scbpm_pkg::FREE_DEPTH);
  assign k_last      = k_q == scbpm_pkg::POOL_W'(scbpm_pkg::POOLS - 1);
  assign k_next_is_n = k_ext1 == pools_used_q;
  assign j_last      = (j_q + scbpm_pkg::CNT_W'(1)) == cur_cnt;

  assign alloc_act = {1'b0, k_q} < active_q;
  assign alloc_hit = alu_ge && (fill_q[k_q] != '0);
  assign spill_hit = (length_q > scbpm_pkg::LEN_W'(scbpm_pkg::SPILL_LOW))
                  && (length_q <= scbpm_pkg::LEN_W'(scbpm_pkg::SPILL_HIGH))
                  && (limit_q[k_q] > scbpm_pkg::LEN_W'(scbpm_pkg::SPILL_HIGH));

  assign free_bad_early = (active_q == '0) || (boff_q == '0)
                       || ({1'b0, boff_q} >= scbpm_pkg::HEAP_W'(scbpm_pkg::HEAP_LIMIT));
  assign free_last      = k_ext1 >= active_q;
  assign pool_full      = fill_q[k_q] >= scbpm_pkg::FILL_W'(scbpm_pkg::FREE_DEPTH);

  // Shared adder / comparator: carry out of a subtract means a >= b
  assign alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                 + scbpm_pkg::alu_res_t'(alu_sub);
  assign alu_ge  = alu_res[scbpm_pkg::ALU_W];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      scbpm_pkg::ST_IDLE: begin
        if (accept) begin
          if (func_i == scbpm_pkg::FUNC_INIT) begin
            state_d = scbpm_pkg::ST_I_START;
          end else if (func_i == scbpm_pkg::FUNC_ALLOC) begin
            state_d = (length_i == '0) ? scbpm_pkg::ST_RESP : scbpm_pkg::ST_A_SCAN;
          end else if (func_i == scbpm_pkg::FUNC_FREE) begin
            state_d = scbpm_pkg::ST_F_CHK;
          end else begin
            state_d = scbpm_pkg::ST_RESP;
          end
        end
      end
      scbpm_pkg::ST_I_START: state_d = n_bad ? scbpm_pkg::ST_RESP : scbpm_pkg::ST_I_CHK;
      scbpm_pkg::ST_I_CHK:   state_d = cnt_bad ? scbpm_pkg::ST_RESP : scbpm_pkg::ST_I_ACC;
      scbpm_pkg::ST_I_ACC:   state_d = k_next_is_n ? scbpm_pkg::ST_I_CMP : scbpm_pkg::ST_I_CHK;
      scbpm_pkg::ST_I_CMP:   state_d = alu_ge ? scbpm_pkg::ST_L_POOL : scbpm_pkg::ST_RESP;
      scbpm_pkg::ST_L_POOL: begin
        if (k_in_n && (cur_cnt != '0)) begin
          state_d = scbpm_pkg::ST_L_BUF;
        end else if (k_last) begin
          state_d = scbpm_pkg::ST_RESP;
        end
      end
      scbpm_pkg::ST_L_BUF: begin
        if (j_last) begin
          state_d = k_last ? scbpm_pkg::ST_RESP : scbpm_pkg::ST_L_POOL;
        end
      end
      scbpm_pkg::ST_A_SCAN: begin
        priority if (!alloc_act) begin
          state_d = scbpm_pkg::ST_RESP;
        end else if (alloc_hit) begin
          state_d = scbpm_pkg::ST_A_TAKE;
        end else if (k_last) begin
          state_d = scbpm_pkg::ST_RESP;
        end
      end
      scbpm_pkg::ST_A_TAKE: state_d = scbpm_pkg::ST_RESP;
      scbpm_pkg::ST_F_CHK: begin
        state_d = (free_bad_early || !alu_ge) ? scbpm_pkg::ST_RESP : scbpm_pkg::ST_F_LO;
      end
      scbpm_pkg::ST_F_LO: state_d = alu_ge ? scbpm_pkg::ST_F_SCAN : scbpm_pkg::ST_RESP;
      scbpm_pkg::ST_F_SCAN: begin
        if (free_last || !alu_ge) begin
          state_d = scbpm_pkg::ST_F_PUSH;
        end
      end
      scbpm_pkg::ST_F_PUSH: state_d = scbpm_pkg::ST_RESP;
      scbpm_pkg::ST_RESP: begin
        if (out_free) begin
          state_d = scbpm_pkg::ST_IDLE;
        end
      end
      default: state_d = scbpm_pkg::ST_IDLE;
    endcase
  end

  // Datapath control: ALU operands, memory ports, result staging
  always_comb begin
    alu_a      = '0;
    alu_b      = '0;
    alu_sub    = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = {k_q, j_q[scbpm_pkg::HEAD_W-1:0]};
    mem_wdata  = pos_q[scbpm_pkg::OFF_W-1:0] + scbpm_pkg::OFF_W'(scbpm_pkg::LINK_BYTES);
    mem_re     = 1'b0;
    mem_raddr  = {k_q, head_q[k_q]};
    res_ld     = 1'b0;
    res_status = scbpm_pkg::STATUS_DONE;
    res_off    = '0;
    res_pool   = '0;
    res_left   = '0;
    lay_done   = 1'b0;
    unique case (state_q)
      scbpm_pkg::ST_IDLE: begin
        if (accept) begin
          if (func_i == scbpm_pkg::FUNC_ALLOC) begin
            if (length_i == '0) begin
              res_ld     = 1'b1;
              res_status = scbpm_pkg::STATUS_BAD_REQ;
            end
          end else if ((func_i != scbpm_pkg::FUNC_INIT) && (func_i != scbpm_pkg::FUNC_FREE)) begin
            res_ld     = 1'b1;
            res_status = scbpm_pkg::STATUS_BAD_REQ;
          end
        end
      end
      scbpm_pkg::ST_I_START: begin
        if (n_bad) begin
          res_ld     = 1'b1;
          res_status = scbpm_pkg::STATUS_BAD_REQ;
        end
      end
      scbpm_pkg::ST_I_CHK: begin
        if (cnt_bad) begin
          res_ld     = 1'b1;
          res_status = scbpm_pkg::STATUS_BAD_REQ;
        end
      end
      scbpm_pkg::ST_I_ACC: begin
        alu_a = scbpm_pkg::ALU_W'(acc_q);
        alu_b = scbpm_pkg::ALU_W'(prod_q);
      end
      scbpm_pkg::ST_I_CMP: begin
        alu_a   = scbpm_pkg::ALU_W'(heap_eff);
        alu_b   = scbpm_pkg::ALU_W'(acc_q);
        alu_sub = 1'b1;
        if (!alu_ge) begin
          res_ld     = 1'b1;
          res_status = scbpm_pkg::STATUS_HEAP_SMALL;
        end
      end
      scbpm_pkg::ST_L_POOL: begin
        if (!(k_in_n && (cur_cnt != '0)) && k_last) begin
          lay_done = 1'b1;
          res_ld   = 1'b1;
        end
      end
      scbpm_pkg::ST_L_BUF: begin
        alu_a  = scbpm_pkg::ALU_W'(pos_q);
        alu_b  = scbpm_pkg::ALU_W'(step);
        mem_we = 1'b1;
        if (j_last && k_last) begin
          lay_done = 1'b1;
          res_ld   = 1'b1;
        end
      end
      scbpm_pkg::ST_A_SCAN: begin
        alu_a   = scbpm_pkg::ALU_W'(limit_q[k_q]);
        alu_b   = scbpm_pkg::ALU_W'(length_q);
        alu_sub = 1'b1;
        if (alloc_act && alloc_hit) begin
          mem_re = 1'b1;
        end else if (!alloc_act || k_last) begin
          res_ld     = 1'b1;
          res_status = scbpm_pkg::STATUS_NO_FIT;
        end
      end
      scbpm_pkg::ST_A_TAKE: begin
        res_ld   = 1'b1;
        res_off  = mem_rdata_q;
        res_pool = k_q;
        res_left = fill_q[k_q] - scbpm_pkg::FILL_W'(1);
      end
      scbpm_pkg::ST_F_CHK: begin
        alu_a   = scbpm_pkg::ALU_W'(boff_q);
        alu_b   = scbpm_pkg::ALU_W'(scbpm_pkg::LINK_BYTES);
        alu_sub = 1'b1;
        if (free_bad_early || !alu_ge) begin
          res_ld     = 1'b1;
          res_status = scbpm_pkg::STATUS_BAD_REQ;
        end
      end
      scbpm_pkg::ST_F_LO: begin
        alu_a   = scbpm_pkg::ALU_W'(link_q);
        alu_b   = scbpm_pkg::ALU_W'(start_q[0]);
        alu_sub = 1'b1;
        if (!alu_ge) begin
          res_ld     = 1'b1;
          res_status = scbpm_pkg::STATUS_BAD_REQ;
        end
      end
      scbpm_pkg::ST_F_SCAN: begin
        alu_a   = scbpm_pkg::ALU_W'(link_q);
        alu_b   = scbpm_pkg::ALU_W'(start_q[k_inc]);
        alu_sub = 1'b1;
      end
      scbpm_pkg::ST_F_PUSH: begin
        res_ld   = 1'b1;
        res_pool = k_q;
        mem_waddr = {k_q, head_q[k_q] + fill_q[k_q][scbpm_pkg::HEAD_W-1:0]};
        mem_wdata = boff_q;
        if (pool_full) begin
          res_status = scbpm_pkg::STATUS_POOL_FULL;
          res_left   = fill_q[k_q];
        end else begin
          mem_we   = 1'b1;
          res_left = fill_q[k_q] + scbpm_pkg::FILL_W'(1);
        end
      end
      scbpm_pkg::ST_RESP: begin
        res_ld = 1'b0;
      end
      default: begin
        res_ld = 1'b0;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pools_used_q <= scbpm_pkg::POOLS_USED_RST;
      heap_q       <= scbpm_pkg::HEAP_BYTES_RST;
      for (int i = 0; i < scbpm_pkg::POOLS; i++) begin
        setup_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_index_i == scbpm_pkg::CFG_POOLS_USED) begin
        pools_used_q <= cfg_wdata_i[scbpm_pkg::NUM_W-1:0];
      end else if (cfg_index_i == scbpm_pkg::CFG_HEAP_BYTES) begin
        heap_q <= cfg_wdata_i[scbpm_pkg::HEAP_W-1:0];
      end else if ((cfg_index_i >= scbpm_pkg::CFG_POOL0_SETUP)
                && (cfg_index_i <= scbpm_pkg::CFG_POOL3_SETUP)) begin
        setup_q[scbpm_pkg::POOL_W'(cfg_index_i - scbpm_pkg::CFG_POOL0_SETUP)] <= cfg_wdata_i;
      end
    end
  end

  // Sequencer and pool bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= scbpm_pkg::ST_IDLE;
      k_q         <= '0;
      j_q         <= '0;
      active_q    <= '0;
      spill_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < scbpm_pkg::POOLS; i++) begin
        fill_q[i]  <= '0;
        head_q[i]  <= '0;
        start_q[i] <= '0;
        limit_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;

      // response register
      if ((state_q == scbpm_pkg::ST_RESP) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        scbpm_pkg::ST_IDLE: begin
          k_q <= '0;
        end
        scbpm_pkg::ST_I_ACC: begin
          if (!k_next_is_n) begin
            k_q <= k_inc;
          end
        end
        scbpm_pkg::ST_I_CMP: begin
          k_q <= '0;
        end
        scbpm_pkg::ST_L_POOL: begin
          // lay out a configured pool, clear the rest
          j_q <= '0;
          if (k_in_n) begin
            start_q[k_q] <= pos_q;
            limit_q[k_q] <= cur_sz;
            fill_q[k_q]  <= cur_cnt;
            head_q[k_q]  <= '0;
          end else begin
            start_q[k_q] <= '0;
            limit_q[k_q] <= '0;
            fill_q[k_q]  <= '0;
            head_q[k_q]  <= '0;
          end
          if (!(k_in_n && (cur_cnt != '0)) && !k_last) begin
            k_q <= k_inc;
          end
          if (lay_done) begin
            active_q <= pools_used_q;
          end
        end
        scbpm_pkg::ST_L_BUF: begin
          j_q <= j_q + scbpm_pkg::CNT_W'(1);
          if (j_last && !k_last) begin
            k_q <= k_inc;
          end
          if (lay_done) begin
            active_q <= pools_used_q;
          end
        end
        scbpm_pkg::ST_A_SCAN: begin
          if (alloc_act && !alloc_hit && !k_last) begin
            k_q <= k_inc;
          end
        end
        scbpm_pkg::ST_A_TAKE: begin
          head_q[k_q] <= head_q[k_q] + scbpm_pkg::HEAD_W'(1);
          fill_q[k_q] <= fill_q[k_q] - scbpm_pkg::FILL_W'(1);
          if (spill_hit) begin
            spill_q <= spill_q + scbpm_pkg::SPILL_W'(1);
          end
        end
        scbpm_pkg::ST_F_LO: begin
          k_q <= '0;
        end
        scbpm_pkg::ST_F_SCAN: begin
          if (!free_last && alu_ge) begin
            k_q <= k_inc;
          end
        end
        scbpm_pkg::ST_F_PUSH: begin
          if (!pool_full) begin
            fill_q[k_q] <= fill_q[k_q] + scbpm_pkg::FILL_W'(1);
          end
        end
        default: begin
          k_q <= k_q;
        end
      endcase
    end
  end

  // Working and payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q   <= func_i;
      length_q <= length_i;
      boff_q   <= buffer_offset_i;
    end
    if (state_q == scbpm_pkg::ST_I_START) begin
      acc_q <= scbpm_pkg::ACC_W'(hdr);
    end else if (state_q == scbpm_pkg::ST_I_ACC) begin
      acc_q <= alu_res[scbpm_pkg::ACC_W-1:0];
    end
    if (state_q == scbpm_pkg::ST_I_CHK) begin
      prod_q <= step * cur_cnt;
    end
    if (state_q == scbpm_pkg::ST_I_CMP) begin
      pos_q <= scbpm_pkg::START_W'(hdr);
    end else if (state_q == scbpm_pkg::ST_L_BUF) begin
      pos_q <= alu_res[scbpm_pkg::START_W-1:0];
    end
    if (state_q == scbpm_pkg::ST_F_CHK) begin
      link_q <= alu_res[scbpm_pkg::OFF_W-1:0];
    end
    if (res_ld) begin
      res_status_q <= res_status;
      res_off_q    <= res_off;
      res_pool_q   <= res_pool;
      res_left_q   <= res_left;
    end
    if ((state_q == scbpm_pkg::ST_RESP) && out_free) begin
      out_status_q <= res_status_q;
      out_off_q    <= res_off_q;
      out_pool_q   <= res_pool_q;
      out_left_q   <= res_left_q;
      out_spill_q  <= spill_q;
    end
  end

  // Free-list memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  assign in_ready_o     = (state_q == scbpm_pkg::ST_IDLE) && (func_q == func_q);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign data_offset_o  = out_off_q;
  assign pool_index_o   = out_pool_q;
  assign buffers_left_o = out_left_q;
  assign spill_count_o  = out_spill_q;

endmodule
